### sv/lie_pkg.sv
// Shared types, constants and fixed-point helpers of the Lagrange evaluator.
// No dependencies; imported by lie_div, lie_seq and the top level.
package lie_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int Q_FRAC        = 24;
    localparam int NUM_W         = 57;   // (x - xj) * 2^24, signed
    localparam int DEN_W         = 33;   // xi - xj, signed
    localparam int PROD_W        = 64;
    localparam int TERM_W        = 40;   // product / 2^24, signed
    localparam int NC_W          = 5;

    localparam logic [NC_W-1:0] NODE_COUNT_RESET = 5'd15;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd16777216;

    typedef struct packed {
        logic                     command;
        logic [3:0]               node_index;
        logic signed [DATA_W-1:0] node_abscissa;
        logic signed [DATA_W-1:0] node_ordinate;
        logic signed [DATA_W-1:0] query_point;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] interpolated_value;
        logic                     saturated;
        logic                     duplicate_node_error;
    } t_out_item;

    // Divide by 2^24, rounding toward zero.
    function automatic logic signed [TERM_W-1:0] q24_trunc(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] b;
        b = p + (p[PROD_W-1] ? 64'sd16777215 : 64'sd0);
        return b[PROD_W-1:Q_FRAC];
    endfunction

    function automatic logic sat_hit(input logic signed [PROD_W-1:0] v);
        return (v > 64'sd2147483647) || (v < -64'sd2147483648);
    endfunction

    function automatic logic signed [DATA_W-1:0] clip32(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

### sv/lie_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lie_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] i_waddr,
    input  logic [Width-1:0]                       i_wdata,
    input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] i_raddr,
    output logic [Width-1:0]                       o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### sv/lie_div.sv
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating.
// Depends on lie_pkg.
module lie_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [lie_pkg::NUM_W-1:0]  i_dividend,
    input  logic signed [lie_pkg::DEN_W-1:0]  i_divisor,
    output logic                              o_done,
    output logic signed [lie_pkg::NUM_W-1:0]  o_quotient
);
    import lie_pkg::*;

    localparam int MagW = NUM_W - 1;
    localparam int DmW  = DEN_W - 1;
    localparam int CntW = $clog2(MagW + 1);

    logic            r_busy, r_done, r_neg;
    logic [CntW-1:0] r_cnt;
    logic [DmW-1:0]  r_rem, r_dsor;
    logic [MagW-1:0] r_quo;

    logic signed [NUM_W-1:0] neg_num;
    logic signed [DEN_W-1:0] neg_den;
    logic [DmW:0]            trial;
    logic                    ge;

    assign neg_num = -i_dividend;
    assign neg_den = -i_divisor;
    assign trial   = {r_rem, r_quo[MagW-1]};
    assign ge      = (trial >= {1'b0, r_dsor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CntW'(MagW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quo  <= i_dividend[NUM_W-1] ? neg_num[MagW-1:0] : i_dividend[MagW-1:0];
            r_dsor <= i_divisor[DEN_W-1] ? neg_den[DmW-1:0] : i_divisor[DmW-1:0];
            r_neg  <= i_dividend[NUM_W-1] ^ i_divisor[DEN_W-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= ge ? DmW'(trial - {1'b0, r_dsor}) : trial[DmW-1:0];
            r_quo <= {r_quo[MagW-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
endmodule

### sv/lie_seq.sv
// Evaluation sequencer: node stores, duplicate scan, basis products and sum.
// Depends on lie_pkg, lie_ram and lie_div.
module lie_seq #(
    parameter int MaxNodes = lie_pkg::MAX_NODES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  lie_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output lie_pkg::t_out_item          o_out_data,
    input  logic [lie_pkg::NC_W-1:0]    i_node_count
);
    import lie_pkg::*;

    localparam int AW   = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
    localparam int CW   = $clog2(MaxNodes + 1);
    localparam int AccW = TERM_W + $clog2(MaxNodes);

    localparam logic [3:0] S_IDLE  = 4'd0,  S_DRI  = 4'd1,  S_DLI  = 4'd2,  S_DRJ  = 4'd3,
                           S_DCJ   = 4'd4,  S_MRI  = 4'd5,  S_MLI  = 4'd6,  S_MJCHK = 4'd7,
                           S_MLJ   = 4'd8,  S_MDIV = 4'd9,  S_MMB  = 4'd10, S_MSB  = 4'd11,
                           S_MTERM = 4'd12, S_MACC = 4'd13, S_MFIN = 4'd14, S_OUT  = 4'd15;

    logic [3:0]               r_state, n_state;
    logic                     r_ovalid, n_ovalid;
    logic [CW-1:0]            r_i, n_i, r_j, n_j, r_n, n_n;
    logic signed [DATA_W-1:0] r_x, n_x, r_xi, n_xi, r_yi, n_yi;
    logic signed [DATA_W-1:0] r_basis, n_basis, r_factor, n_factor, r_res, n_res;
    logic signed [AccW-1:0]   r_acc, n_acc;
    logic                     r_sat, n_sat, r_dup, n_dup;
    logic signed [PROD_W-1:0] r_prod;
    t_out_item                r_out, n_out;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic signed [DATA_W-1:0] x_rd, y_rd;
    logic                     div_start, div_done;
    logic signed [NUM_W-1:0]  div_num, div_q;
    logic signed [DEN_W-1:0]  div_den, dx;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [TERM_W-1:0] t_q;
    logic signed [PROD_W-1:0] t_q64, q64, acc64;
    logic                     accept;
    logic [CW:0]              i_nxt, j_nxt;
    int                       nc_int;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Stores are written only while idle, so a read never overlaps a write.
    assign ram_we    = accept && (i_in_data.command == CMD_LOAD)
                       && (int'(i_in_data.node_index) < MaxNodes);
    assign ram_waddr = AW'(i_in_data.node_index);
    assign ram_raddr = (r_state == S_DRJ || r_state == S_MJCHK) ? r_j[AW-1:0] : r_i[AW-1:0];

    lie_ram #(.Width(DATA_W), .Depth(MaxNodes)) u_xram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr),
        .i_wdata(i_in_data.node_abscissa), .i_raddr(ram_raddr), .o_rdata(x_rd)
    );

    lie_ram #(.Width(DATA_W), .Depth(MaxNodes)) u_yram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr),
        .i_wdata(i_in_data.node_ordinate), .i_raddr(ram_raddr), .o_rdata(y_rd)
    );

    assign dx        = {r_x[DATA_W-1], r_x} - {x_rd[DATA_W-1], x_rd};
    assign div_num   = {dx, {Q_FRAC{1'b0}}};
    assign div_den   = {r_xi[DATA_W-1], r_xi} - {x_rd[DATA_W-1], x_rd};
    assign div_start = (r_state == S_MLJ);

    lie_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(div_num), .i_divisor(div_den), .o_done(div_done), .o_quotient(div_q)
    );

    // One shared multiplier: basis update, then the ordinate term.
    assign mul_a = (r_state == S_MMB) ? r_basis : r_yi;
    assign mul_b = (r_state == S_MMB) ? r_factor : r_basis;

    assign t_q    = q24_trunc(r_prod);
    assign t_q64  = {{(PROD_W-TERM_W){t_q[TERM_W-1]}}, t_q};
    assign q64    = {{(PROD_W-NUM_W){div_q[NUM_W-1]}}, div_q};
    assign acc64  = {{(PROD_W-AccW){r_acc[AccW-1]}}, r_acc};
    assign i_nxt  = {1'b0, r_i} + 1'b1;
    assign j_nxt  = {1'b0, r_j} + 1'b1;
    assign nc_int = int'(i_node_count);

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !i_out_ready;
        n_i      = r_i;
        n_j      = r_j;
        n_n      = r_n;
        n_x      = r_x;
        n_xi     = r_xi;
        n_yi     = r_yi;
        n_basis  = r_basis;
        n_factor = r_factor;
        n_res    = r_res;
        n_acc    = r_acc;
        n_sat    = r_sat;
        n_dup    = r_dup;
        n_out    = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_in_data.command == CMD_EVAL) begin
                    n_x   = i_in_data.query_point;
                    n_i   = '0;
                    n_dup = 1'b0;
                    if (nc_int < 2) begin
                        n_n = CW'(2);
                    end else if (nc_int > MaxNodes) begin
                        n_n = CW'(MaxNodes);
                    end else begin
                        n_n = CW'(nc_int);
                    end
                    n_state = S_DRI;
                end
            end
            S_DRI: n_state = S_DLI;
            S_DLI: begin
                n_xi = x_rd;
                n_j  = i_nxt[CW-1:0];
                if (i_nxt >= {1'b0, r_n}) begin
                    if (r_dup) begin
                        n_res   = '0;
                        n_sat   = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_i     = '0;
                        n_acc   = '0;
                        n_sat   = 1'b0;
                        n_state = S_MRI;
                    end
                end else begin
                    n_state = S_DRJ;
                end
            end
            S_DRJ: n_state = S_DCJ;
            S_DCJ: begin
                if (x_rd == r_xi) begin
                    n_dup = 1'b1;
                end
                if (j_nxt >= {1'b0, r_n}) begin
                    n_i     = i_nxt[CW-1:0];
                    n_state = S_DRI;
                end else begin
                    n_j     = j_nxt[CW-1:0];
                    n_state = S_DRJ;
                end
            end
            S_MRI: n_state = S_MLI;
            S_MLI: begin
                n_xi    = x_rd;
                n_yi    = y_rd;
                n_basis = Q_ONE;
                n_j     = '0;
                n_state = S_MJCHK;
            end
            S_MJCHK: begin
                if (r_j >= r_n) begin
                    n_state = S_MTERM;
                end else if (r_j == r_i) begin
                    n_j = j_nxt[CW-1:0];
                end else begin
                    n_state = S_MLJ;
                end
            end
            S_MLJ: n_state = S_MDIV;
            S_MDIV: begin
                if (div_done) begin
                    n_factor = clip32(q64);
                    n_sat    = r_sat | sat_hit(q64);
                    n_state  = S_MMB;
                end
            end
            S_MMB: n_state = S_MSB;
            S_MSB: begin
                n_basis = clip32(t_q64);
                n_sat   = r_sat | sat_hit(t_q64);
                n_j     = j_nxt[CW-1:0];
                n_state = S_MJCHK;
            end
            S_MTERM: n_state = S_MACC;
            S_MACC: begin
                n_acc = r_acc + {{(AccW-TERM_W){t_q[TERM_W-1]}}, t_q};
                if (i_nxt >= {1'b0, r_n}) begin
                    n_state = S_MFIN;
                end else begin
                    n_i     = i_nxt[CW-1:0];
                    n_state = S_MRI;
                end
            end
            S_MFIN: begin
                n_res   = clip32(acc64);
                n_sat   = r_sat | sat_hit(acc64);
                n_state = S_OUT;
            end
            S_OUT: begin
                // Hold until the previous result has been taken.
                if (!r_ovalid) begin
                    n_out.interpolated_value   = r_res;
                    n_out.saturated            = r_sat;
                    n_out.duplicate_node_error = r_dup;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_n      <= n_n;
        r_x      <= n_x;
        r_xi     <= n_xi;
        r_yi     <= n_yi;
        r_basis  <= n_basis;
        r_factor <= n_factor;
        r_res    <= n_res;
        r_acc    <= n_acc;
        r_sat    <= n_sat;
        r_dup    <= n_dup;
        r_out    <= n_out;
        if (r_state == S_MMB || r_state == S_MTERM) begin
            r_prod <= mul_a * mul_b;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_no_self_factor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MLJ) |-> (r_j != r_i))
        else $error("basis factor started with j equal to i");
    a_dup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.duplicate_node_error)
            |-> (r_out.interpolated_value == '0 && !r_out.saturated))
        else $error("duplicate result carries a value");
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_MDIV))
        else $error("divider finished outside its wait state");
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE))
        else $error("node store written during evaluation");
`endif
endmodule

### sv/lagrange_interpolation_eval.sv
// Lagrange evaluator: loads give no result. An evaluate transfer first scans
// all node pairs for equal abscissas. If one is found, the result is zero with
// the duplicate flag set. Else, for each node i and each other node j, it waits
// on the shared bit-serial divider for the 56 quotient bits of (x - xj) / (xi - xj)
// and multiplies that factor into the basis; each basis times yi is then added
// to the sum.
// Depends on lie_pkg and lie_seq.
module lagrange_interpolation_eval #(
    parameter int MaxNodes = lie_pkg::MAX_NODES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  lie_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output lie_pkg::t_out_item    o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import lie_pkg::*;

    logic [NC_W-1:0] r_node_count;
    logic            reg_sel;

    assign reg_sel = (paddr[2] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {{(32-NC_W){1'b0}}, r_node_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_node_count <= pwdata[NC_W-1:0];
        end
    end

    lie_seq #(.MaxNodes(MaxNodes)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_node_count(r_node_count)
    );
endmodule
